// ===== rtl/deq_pkg.sv =====
// Package: types, codes and default sizes of the double-ended queue unit.
package deq_pkg;

  localparam int unsigned CAPACITY_DEF    = 16;
  localparam int unsigned VALUE_WIDTH_DEF = 32;

  localparam int unsigned REQ_W    = 3;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 5;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH_FRONT = 3'd0,
    REQ_PUSH_BACK  = 3'd1,
    REQ_POP_FRONT  = 3'd2,
    REQ_POP_BACK   = 3'd3,
    REQ_REVERSE    = 3'd4
  } req_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_EXEC = 2'd1,
    ST_ENDS = 2'd2,
    ST_PACK = 2'd3
  } state_e;

  typedef struct packed {
    logic capture;
    logic exec;
    logic ends;
    logic pack;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } stat_t;

endpackage

// ===== rtl/deq_if.sv =====
// Interfaces: request and response channels of the double-ended queue unit.
interface deq_req_if;
  logic                          valid;
  logic                          ready;
  logic [deq_pkg::REQ_W-1:0]     req_type;
  logic [deq_pkg::DATA_W-1:0]    push_value;

  modport source (output valid, output req_type, output push_value, input ready);
  modport sink   (input valid, input req_type, input push_value, output ready);
endinterface

interface deq_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [deq_pkg::STATUS_W-1:0]  status;
  logic [deq_pkg::DATA_W-1:0]    popped_value;
  logic [deq_pkg::DATA_W-1:0]    front_value;
  logic [deq_pkg::DATA_W-1:0]    back_value;
  logic [deq_pkg::COUNT_W-1:0]   entry_count;
  logic                          is_empty;

  modport source (output valid, output status, output popped_value, output front_value,
                  output back_value, output entry_count, output is_empty, input ready);
  modport sink   (input valid, input status, input popped_value, input front_value,
                  input back_value, input entry_count, input is_empty, output ready);
endinterface

// ===== rtl/double_ended_queue_unit.sv =====
// Top level: bounded double-ended queue with a ring store, head pointer and direction flag.
//
//   channel  dir  port   payload
//   request  in   req_i  req_type, push_value
//   response out  rsp_o  status, popped_value, front_value, back_value, entry_count, is_empty
//
// A request passes capture on the accept edge, then execute (store write or pop read), end read
// (both ends through the two store read ports), then load.
// The next request is accepted in the cycle after the response is loaded, while it waits.
// A response held by rsp_o.ready stalls the sequencer before its next load.
// Reset clears head, count and direction; the store itself is not cleared.
module double_ended_queue_unit #(
  parameter int unsigned CAPACITY    = deq_pkg::CAPACITY_DEF,
  parameter int unsigned VALUE_WIDTH = deq_pkg::VALUE_WIDTH_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  deq_req_if.sink  req_i,
  deq_rsp_if.source rsp_o
);

  deq_pkg::cmd_t  cmd;
  deq_pkg::stat_t stat;

  deq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  deq_datapath #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .req_type_i     (req_i.req_type),
    .push_value_i   (req_i.push_value),
    .out_valid_o    (rsp_o.valid),
    .out_ready_i    (rsp_o.ready),
    .status_o       (rsp_o.status),
    .popped_value_o (rsp_o.popped_value),
    .front_value_o  (rsp_o.front_value),
    .back_value_o   (rsp_o.back_value),
    .entry_count_o  (rsp_o.entry_count),
    .is_empty_o     (rsp_o.is_empty)
  );

endmodule

// ===== rtl/deq_ctrl.sv =====
// Controller: sequences capture, execute, end read and result load per transaction.
module deq_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  output logic           req_ready_o,
  input  deq_pkg::stat_t stat_i,
  output deq_pkg::cmd_t  cmd_o
);

  deq_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= deq_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    req_ready_o = 1'b0;
    cmd_o       = '0;
    case (state_q)
      deq_pkg::ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = deq_pkg::ST_EXEC;
        end
      end
      deq_pkg::ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = deq_pkg::ST_ENDS;
      end
      deq_pkg::ST_ENDS: begin
        cmd_o.ends = 1'b1;
        state_d    = deq_pkg::ST_PACK;
      end
      deq_pkg::ST_PACK: begin
        if (stat_i.out_free) begin
          cmd_o.pack = 1'b1;
          state_d    = deq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = deq_pkg::ST_IDLE;
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.capture, cmd_o.exec, cmd_o.ends, cmd_o.pack}))
    else $error("controller issued more than one command");
  a_exec_follows_capture: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> cmd_o.exec ##1 cmd_o.ends)
    else $error("execute or end read did not follow capture");
`endif

endmodule

// ===== rtl/deq_datapath.sv =====
// Datapath: ring store, head pointer, count, direction flag and result register.
module deq_datapath #(
  parameter int unsigned CAPACITY    = deq_pkg::CAPACITY_DEF,
  parameter int unsigned VALUE_WIDTH = deq_pkg::VALUE_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  deq_pkg::cmd_t                 cmd_i,
  output deq_pkg::stat_t                stat_o,
  input  logic [deq_pkg::REQ_W-1:0]     req_type_i,
  input  logic [deq_pkg::DATA_W-1:0]    push_value_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [deq_pkg::STATUS_W-1:0]  status_o,
  output logic [deq_pkg::DATA_W-1:0]    popped_value_o,
  output logic [deq_pkg::DATA_W-1:0]    front_value_o,
  output logic [deq_pkg::DATA_W-1:0]    back_value_o,
  output logic [deq_pkg::COUNT_W-1:0]   entry_count_o,
  output logic                          is_empty_o
);

  localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned SW = CW + 1;
  localparam int unsigned VW = VALUE_WIDTH;
  localparam int unsigned DW = deq_pkg::DATA_W;
  localparam int unsigned OW = deq_pkg::COUNT_W;

  localparam logic [IW-1:0] IDX_LAST = IW'(CAPACITY - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(CAPACITY);
  localparam logic [SW-1:0] CAP_S    = SW'(CAPACITY);

  logic [VW-1:0]   mem [CAPACITY];
  logic [VW-1:0]   rd_a_q, rd_b_q;
  logic [IW-1:0]   addr_a;
  logic            mem_we;
  logic [IW-1:0]   waddr;

  deq_pkg::req_e   req_q;
  logic [VW-1:0]   val_q;
  logic [VW-1:0]   val_in;

  logic [IW-1:0]   head_q, head_d;
  logic [CW-1:0]   count_q, count_d;
  logic            rev_q, rev_d;
  deq_pkg::status_e op_status_q, op_status_d;
  logic            pop_hit_q, pop_hit_d;
  logic [IW-1:0]   pop_addr;

  logic [SW-1:0]   tail_sum, tail_wrap, high_sum, high_wrap;
  logic [IW-1:0]   tail_idx, high_idx, head_prev, head_next;
  logic            full, empty, is_push, is_pop, at_low_push, at_low_pop;

  logic [DW-1:0]   rd_a_ext, rd_b_ext;
  logic [DW-1:0]   popped_q;
  logic [OW-1:0]   count_ext;

  logic                          out_valid_q;
  deq_pkg::status_e              out_status_q;
  logic [DW-1:0]                 out_popped_q, out_front_q, out_back_q;
  logic [OW-1:0]                 out_count_q;
  logic                          out_empty_q;

  // width adaptation between the 32-bit ports and the stored value width
  if (VW >= DW) begin : g_wide
    assign val_in   = VW'(push_value_i);
    assign rd_a_ext = rd_a_q[DW-1:0];
    assign rd_b_ext = rd_b_q[DW-1:0];
  end else begin : g_narrow
    assign val_in   = push_value_i[VW-1:0];
    assign rd_a_ext = {{(DW-VW){1'b0}}, rd_a_q};
    assign rd_b_ext = {{(DW-VW){1'b0}}, rd_b_q};
  end

  if (CW >= OW) begin : g_cnt_wide
    assign count_ext = count_q[OW-1:0];
  end else begin : g_cnt_narrow
    assign count_ext = {{(OW-CW){1'b0}}, count_q};
  end

  // ring arithmetic
  assign tail_sum  = SW'(head_q) + SW'(count_q);
  assign tail_wrap = (tail_sum >= CAP_S) ? tail_sum - CAP_S : tail_sum;
  assign tail_idx  = tail_wrap[IW-1:0];
  assign high_sum  = tail_sum - SW'(1);
  assign high_wrap = (high_sum >= CAP_S) ? high_sum - CAP_S : high_sum;
  assign high_idx  = high_wrap[IW-1:0];
  assign head_prev = (head_q == '0) ? IDX_LAST : head_q - IW'(1);
  assign head_next = (head_q == IDX_LAST) ? '0 : head_q + IW'(1);

  assign full        = (count_q == CNT_FULL);
  assign empty       = (count_q == '0);
  assign is_push     = (req_q == deq_pkg::REQ_PUSH_FRONT) || (req_q == deq_pkg::REQ_PUSH_BACK);
  assign is_pop      = (req_q == deq_pkg::REQ_POP_FRONT) || (req_q == deq_pkg::REQ_POP_BACK);
  assign at_low_push = (req_q == deq_pkg::REQ_PUSH_FRONT) != rev_q;
  assign at_low_pop  = (req_q == deq_pkg::REQ_POP_FRONT) != rev_q;
  assign pop_addr    = at_low_pop ? head_q : high_idx;

  always_comb begin
    head_d      = head_q;
    count_d     = count_q;
    rev_d       = rev_q;
    op_status_d = op_status_q;
    pop_hit_d   = pop_hit_q;
    mem_we      = 1'b0;
    waddr       = tail_idx;
    if (cmd_i.exec) begin
      op_status_d = deq_pkg::STAT_OK;
      pop_hit_d   = 1'b0;
      if (is_push) begin
        if (full) begin
          op_status_d = deq_pkg::STAT_FULL;
        end else begin
          mem_we  = 1'b1;
          count_d = count_q + CW'(1);
          if (at_low_push) begin
            waddr  = head_prev;
            head_d = head_prev;
          end
        end
      end else if (is_pop) begin
        if (empty) begin
          op_status_d = deq_pkg::STAT_EMPTY;
        end else begin
          pop_hit_d = 1'b1;
          count_d   = count_q - CW'(1);
          if (at_low_pop) begin
            head_d = head_next;
          end
        end
      end else if (req_q == deq_pkg::REQ_REVERSE) begin
        rev_d = ~rev_q;
      end
    end
  end

  // pop read on execute, low end otherwise so it holds while the load stalls
  assign addr_a = cmd_i.exec ? pop_addr : head_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[waddr] <= val_q;
    end
    rd_a_q <= mem[addr_a];
    rd_b_q <= mem[high_idx];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      count_q     <= '0;
      rev_q       <= 1'b0;
      op_status_q <= deq_pkg::STAT_OK;
      pop_hit_q   <= 1'b0;
    end else begin
      head_q      <= head_d;
      count_q     <= count_d;
      rev_q       <= rev_d;
      op_status_q <= op_status_d;
      pop_hit_q   <= pop_hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q <= deq_pkg::req_e'(req_type_i);
      val_q <= val_in;
    end
    if (cmd_i.ends) begin
      popped_q <= pop_hit_q ? rd_a_ext : '0;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.pack) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pack) begin
      out_status_q <= op_status_q;
      out_popped_q <= popped_q;
      out_front_q  <= empty ? '0 : (rev_q ? rd_b_ext : rd_a_ext);
      out_back_q   <= empty ? '0 : (rev_q ? rd_a_ext : rd_b_ext);
      out_count_q  <= count_ext;
      out_empty_q  <= empty;
    end
  end

  assign stat_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign popped_value_o  = out_popped_q;
  assign front_value_o   = out_front_q;
  assign back_value_o    = out_back_q;
  assign entry_count_o   = out_count_q;
  assign is_empty_o      = out_empty_q;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q <= CNT_FULL) && (head_q <= IDX_LAST))
    else $error("count or head pointer out of range");
  a_refused_push_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec && is_push && full) |=> $stable(count_q) && $stable(head_q))
    else $error("refused push changed the queue");
  a_pop_decrements: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec && is_pop && !empty) |=> (count_q == $past(count_q) - CW'(1)))
    else $error("accepted pop did not decrement count");
  a_pack_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pack |-> (!out_valid_q || out_ready_i))
    else $error("result overwritten before it was taken");
`endif

endmodule

// ===== verif/double_ended_queue_unit_tb.sv =====
// Testbench: directed and random requests to the deque unit, checked against a ring-store model.
module double_ended_queue_unit_tb;
  import deq_pkg::*;

  localparam int CAP = CAPACITY_DEF;
  localparam logic [REQ_W-1:0] REQ_SPARE_LO  = 3'd5;
  localparam logic [REQ_W-1:0] REQ_SPARE_MID = 3'd6;
  localparam logic [REQ_W-1:0] REQ_SPARE_HI  = 3'd7;
  localparam int PHASE_ITEMS = 342;
  localparam int HOLD_CYCLES = 120;
  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [DATA_W-1:0]   popped;
    logic [DATA_W-1:0]   front;
    logic [DATA_W-1:0]   back;
    logic [COUNT_W-1:0]  count;
    logic                empty;
  } rsp_t;

  typedef struct packed {
    logic [REQ_W-1:0]  op;
    logic [DATA_W-1:0] value;
    logic              typed;
    rsp_t              rsp;
  } dir_row_t;

  localparam rsp_t NO_RSP = '0;

  logic clk_i = 1'b0;
  logic rst_ni;

  deq_req_if req_if ();
  deq_rsp_if rsp_if ();

  double_ended_queue_unit DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  logic [DATA_W-1:0] dq_store [CAP];
  int   dq_head;
  int   dq_count;
  bit   dq_rev;

  rsp_t owed_responses [$];
  int   errs;
  int   snd_idle_pct;
  int   rcv_idle_pct;
  int   hold_token;
  int   hold_seen;
  int   hold_left;

  function automatic rsp_t deque_apply(input logic [REQ_W-1:0] op, input logic [DATA_W-1:0] v);
    rsp_t r;
    bit   at_low;
    int   hi_slot;
    r = '0;
    r.status = STAT_OK;
    case (op)
      REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
        if (dq_count >= CAP) begin
          r.status = STAT_FULL;
        end else begin
          at_low = (op == REQ_PUSH_FRONT) != dq_rev;
          if (at_low) begin
            dq_head = (dq_head + CAP - 1) % CAP;
            dq_store[dq_head] = v;
          end else begin
            dq_store[(dq_head + dq_count) % CAP] = v;
          end
          dq_count++;
        end
      end
      REQ_POP_FRONT, REQ_POP_BACK: begin
        if (dq_count == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          at_low = (op == REQ_POP_FRONT) != dq_rev;
          if (at_low) begin
            r.popped = dq_store[dq_head];
            dq_head = (dq_head + 1) % CAP;
          end else begin
            r.popped = dq_store[(dq_head + dq_count - 1) % CAP];
          end
          dq_count--;
        end
      end
      REQ_REVERSE: begin
        dq_rev = !dq_rev;
      end
      default: ;
    endcase
    if (dq_count != 0) begin
      hi_slot = (dq_head + dq_count - 1) % CAP;
      r.front = dq_rev ? dq_store[hi_slot] : dq_store[dq_head];
      r.back  = dq_rev ? dq_store[dq_head] : dq_store[hi_slot];
    end
    r.count = dq_count[COUNT_W-1:0];
    r.empty = (dq_count == 0);
    return r;
  endfunction

  function automatic dir_row_t row(input logic [REQ_W-1:0] op, input logic [DATA_W-1:0] v,
                                   input logic typed, input rsp_t r);
    dir_row_t d;
    d.op = op;
    d.value = v;
    d.typed = typed;
    d.rsp = r;
    return d;
  endfunction

  task automatic send_req(input logic [REQ_W-1:0] op, input logic [DATA_W-1:0] v);
    while ($urandom_range(99) < snd_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid      <= 1'b1;
    req_if.req_type   <= op;
    req_if.push_value <= v;
    @(negedge clk_i);
    while (!req_if.ready) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic compare_field(input string name, input logic [DATA_W-1:0] e,
                               input logic [DATA_W-1:0] a);
    if (a !== e) begin
      $error("%s: expected %0h, got %0h", name, e, a);
      errs++;
    end
  endtask

  // response ready, with one long hold-off on request
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      rsp_if.ready <= 1'b0;
    end else if (hold_seen != hold_token) begin
      hold_seen <= hold_token;
      hold_left <= HOLD_CYCLES;
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // outputs are stable at the falling edge; the transaction completes at the next rising one
  always @(negedge clk_i) begin
    rsp_t e;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (owed_responses.size() == 0) begin
        $error("response with no request outstanding");
        errs++;
      end else begin
        e = owed_responses.pop_front();
        compare_field("status", DATA_W'(e.status), DATA_W'(rsp_if.status));
        compare_field("popped_value", e.popped, rsp_if.popped_value);
        compare_field("front_value", e.front, rsp_if.front_value);
        compare_field("back_value", e.back, rsp_if.back_value);
        compare_field("entry_count", DATA_W'(e.count), DATA_W'(rsp_if.entry_count));
        compare_field("is_empty", DATA_W'(e.empty), DATA_W'(rsp_if.is_empty));
      end
    end
  end

  initial begin
    #(12 * 200000);
    $display("double_ended_queue_unit_tb: errors");
    $finish;
  end

  initial begin
    dir_row_t         dir_tab [$];
    rsp_t             predicted;
    logic [REQ_W-1:0] op;
    logic [DATA_W-1:0] v;
    int               counted;
    int               mode;
    int               push_pct;
    int               pick;
    int               since_mode;

    errs = 0;
    dq_head = 0;
    dq_count = 0;
    dq_rev = 1'b0;
    hold_token = 0;
    hold_seen = 0;
    hold_left = 0;
    snd_idle_pct = 31;
    rcv_idle_pct = 65;
    rst_ni = 1'b0;
    req_if.valid = 1'b0;
    req_if.req_type = REQ_PUSH_FRONT;
    req_if.push_value = '0;
    rsp_if.ready = 1'b0;

    // empty deque, then the two extreme values, then fill to capacity and push once more while full
    dir_tab.push_back(row(REQ_POP_FRONT, 32'h0, 1'b1,
                          '{STAT_EMPTY, 32'h0, 32'h0, 32'h0, 5'd0, 1'b1}));
    dir_tab.push_back(row(REQ_POP_BACK, 32'hFFFF_FFFF, 1'b1,
                          '{STAT_EMPTY, 32'h0, 32'h0, 32'h0, 5'd0, 1'b1}));
    dir_tab.push_back(row(REQ_REVERSE, 32'h0, 1'b1,
                          '{STAT_OK, 32'h0, 32'h0, 32'h0, 5'd0, 1'b1}));
    dir_tab.push_back(row(REQ_SPARE_HI, 32'hFFFF_FFFF, 1'b1,
                          '{STAT_OK, 32'h0, 32'h0, 32'h0, 5'd0, 1'b1}));
    dir_tab.push_back(row(REQ_PUSH_FRONT, 32'hFFFF_FFFF, 1'b1,
                          '{STAT_OK, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd1, 1'b0}));
    dir_tab.push_back(row(REQ_PUSH_BACK, 32'h0, 1'b1,
                          '{STAT_OK, 32'h0, 32'hFFFF_FFFF, 32'h0, 5'd2, 1'b0}));
    dir_tab.push_back(row(REQ_REVERSE, 32'h1234_5678, 1'b1,
                          '{STAT_OK, 32'h0, 32'h0, 32'hFFFF_FFFF, 5'd2, 1'b0}));
    dir_tab.push_back(row(REQ_POP_FRONT, 32'h0, 1'b1,
                          '{STAT_OK, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd1, 1'b0}));
    dir_tab.push_back(row(REQ_PUSH_FRONT, 32'h8000_0000, 1'b0, NO_RSP));
    dir_tab.push_back(row(REQ_PUSH_BACK,  32'h0000_0001, 1'b0, NO_RSP));
    dir_tab.push_back(row(REQ_PUSH_FRONT, 32'hA5A5_A5A5, 1'b0, NO_RSP));
    dir_tab.push_back(row(REQ_PUSH_BACK,  32'h5A5A_5A5A, 1'b0, NO_RSP));
    dir_tab.push_back(row(REQ_PUSH_FRONT, 32'h7FFF_FFFF, 1'b0, NO_RSP));
    dir_tab.push_back(row(REQ_PUSH_BACK,  32'hFFFF_FFFE, 1'b0, NO_RSP));
    dir_tab.push_back(row(REQ_PUSH_FRONT, 32'h0000_00FF, 1'b0, NO_RSP));
    dir_tab.push_back(row(REQ_PUSH_BACK,  32'hFF00_0000, 1'b0, NO_RSP));
    dir_tab.push_back(row(REQ_PUSH_FRONT, 32'h0F0F_0F0F, 1'b0, NO_RSP));
    dir_tab.push_back(row(REQ_PUSH_BACK,  32'hF0F0_F0F0, 1'b0, NO_RSP));
    dir_tab.push_back(row(REQ_PUSH_FRONT, 32'h3333_3333, 1'b0, NO_RSP));
    dir_tab.push_back(row(REQ_PUSH_BACK,  32'hCCCC_CCCC, 1'b0, NO_RSP));
    dir_tab.push_back(row(REQ_PUSH_FRONT, 32'hDEAD_BEEF, 1'b0, NO_RSP));
    dir_tab.push_back(row(REQ_PUSH_BACK,  32'h0BAD_F00D, 1'b0, NO_RSP));
    dir_tab.push_back(row(REQ_PUSH_FRONT, 32'h0000_0002, 1'b0, NO_RSP));
    dir_tab.push_back(row(REQ_PUSH_BACK,  32'h1111_1111, 1'b0, NO_RSP));
    dir_tab.push_back(row(REQ_SPARE_LO,   32'h2222_2222, 1'b0, NO_RSP));
    dir_tab.push_back(row(REQ_POP_BACK,   32'h0, 1'b0, NO_RSP));

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      send_req(dir_tab[i].op, dir_tab[i].value);
      predicted = deque_apply(dir_tab[i].op, dir_tab[i].value);
      owed_responses.push_back(dir_tab[i].typed ? dir_tab[i].rsp : predicted);
    end

    mode = 0;
    since_mode = 0;
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin snd_idle_pct = 31; rcv_idle_pct = 65; end
        1: begin snd_idle_pct = 65; rcv_idle_pct = 31; end
        default: begin snd_idle_pct = 0; rcv_idle_pct = 0; end
      endcase
      counted = 0;
      while (counted < PHASE_ITEMS) begin
        if (since_mode == 0) begin
          mode = $urandom_range(2);
          since_mode = $urandom_range(48, 16);
        end
        since_mode--;
        push_pct = (mode == 0) ? 75 : (mode == 1) ? 25 : 50;
        pick = $urandom_range(99);
        if (pick < 3) begin
          op = REQ_W'($urandom_range(REQ_SPARE_HI, REQ_SPARE_LO));
        end else if (pick < 12) begin
          op = REQ_REVERSE;
        end else if ($urandom_range(99) < push_pct) begin
          op = $urandom_range(1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT;
        end else begin
          op = $urandom_range(1) ? REQ_POP_BACK : REQ_POP_FRONT;
        end
        case ($urandom_range(9))
          0: v = '0;
          1: v = '1;
          default: v = $urandom();
        endcase
        send_req(op, v);
        owed_responses.push_back(deque_apply(op, v));
        if (op <= REQ_REVERSE) begin
          counted++;
          if (phase == 1 && counted == PHASE_ITEMS / 2) begin
            req_if.valid <= 1'b0;
            while (owed_responses.size() != 0) @(posedge clk_i);
            @(posedge clk_i);
          end
          if (phase == 2 && counted == 100) hold_token++;
        end
      end
    end

    req_if.valid <= 1'b0;
    while (owed_responses.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errs == 0) begin
      $display("double_ended_queue_unit_tb: clean");
    end else begin
      $display("double_ended_queue_unit_tb: errors");
    end
    $finish;
  end

endmodule
